### rtl/wsr_pkg.sv
// Shared types and constants for the wildcard and star pattern matcher.
`default_nettype none
package wsr_pkg;

	localparam int MAX_TOKENS = 8;
	localparam int SYM_W      = 8;
	localparam int POS_W      = MAX_TOKENS + 1;
	localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
	localparam int PAT_W      = SYM_W * MAX_TOKENS;
	localparam int CFG_DW     = 64;
	localparam int CFG_AW     = 5;

	localparam logic [SYM_W-1:0] WILDCARD_SYM = 8'd46;
	localparam logic [CNT_W-1:0] TOKENS_MAX   = CNT_W'(MAX_TOKENS);
	localparam logic [POS_W-1:0] START_SET    = POS_W'(1);

	typedef enum logic [1:0] {
		REG_PATTERN = 2'd0,
		REG_STAR    = 2'd1,
		REG_COUNT   = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PAT_W-1:0]      pattern;
		logic [MAX_TOKENS-1:0] star;
		logic [CNT_W-1:0]      count;
	} cfg_t;

endpackage
`default_nettype wire

### rtl/wsr_cfg.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module wsr_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wsr_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [wsr_pkg::CFG_DW-1:0]  pwdata,
	output logic      [wsr_pkg::CFG_DW-1:0]  prdata,
	output logic                             pready,
	output wsr_pkg::cfg_t                    cfg
);

	wsr_pkg::reg_idx_t idx;
	logic              wr_en;
	wsr_pkg::cfg_t     cfg_q;

	assign idx    = wsr_pkg::reg_idx_t'(paddr[wsr_pkg::CFG_AW-1:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				wsr_pkg::REG_PATTERN: cfg_q.pattern <= pwdata[wsr_pkg::PAT_W-1:0];
				wsr_pkg::REG_STAR:    cfg_q.star    <= pwdata[wsr_pkg::MAX_TOKENS-1:0];
				wsr_pkg::REG_COUNT:   cfg_q.count   <= pwdata[wsr_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wsr_pkg::REG_PATTERN: prdata = wsr_pkg::CFG_DW'(cfg_q.pattern);
			wsr_pkg::REG_STAR:    prdata = wsr_pkg::CFG_DW'(cfg_q.star);
			wsr_pkg::REG_COUNT:   prdata = wsr_pkg::CFG_DW'(cfg_q.count);
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/wsr_nfa.sv
// Active position set with star closure and one-symbol advance.
`default_nettype none
module wsr_nfa (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire wsr_pkg::cfg_t              cfg,
	input  wire logic                       step,
	input  wire logic [wsr_pkg::SYM_W-1:0]  symbol,
	input  wire logic                       terminator,
	output logic                            matched
);

	logic [wsr_pkg::POS_W-1:0] active_q;
	logic [wsr_pkg::POS_W-1:0] cur;
	logic [wsr_pkg::POS_W-1:0] nxt;
	logic [wsr_pkg::CNT_W-1:0] used;
	logic [wsr_pkg::SYM_W-1:0] tok;
	logic                      hit;

	assign used = (cfg.count > wsr_pkg::TOKENS_MAX) ? wsr_pkg::TOKENS_MAX : cfg.count;

	// Positions above the token count are dropped, then each starred token
	// passes its position on to the next one.
	always_comb begin
		cur = active_q;
		for (int p = 0; p < wsr_pkg::POS_W; p++) begin
			if (p > int'(used)) begin
				cur[p] = 1'b0;
			end
		end
		for (int k = 0; k < wsr_pkg::MAX_TOKENS; k++) begin
			if (k < int'(used) && cur[k] && cfg.star[k]) begin
				cur[k+1] = 1'b1;
			end
		end
	end

	always_comb begin
		nxt = '0;
		tok = '0;
		hit = 1'b0;
		for (int k = 0; k < wsr_pkg::MAX_TOKENS; k++) begin
			tok = cfg.pattern[k*wsr_pkg::SYM_W +: wsr_pkg::SYM_W];
			hit = cur[k] && (k < int'(used))
				&& (tok == wsr_pkg::WILDCARD_SYM || tok == symbol);
			if (hit) begin
				if (cfg.star[k]) begin
					nxt[k] = 1'b1;
				end else begin
					nxt[k+1] = 1'b1;
				end
			end
		end
	end

	assign matched = cur[used];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= wsr_pkg::START_SET;
		end else if (step) begin
			active_q <= terminator ? wsr_pkg::START_SET : nxt;
		end
	end

endmodule
`default_nettype wire

### rtl/wildcard_star_regex_match.sv
// Top level of the streaming matcher for literal, wildcard and star patterns.
//
// Usage: program the pattern through the APB-style port while the block is
// idle: pattern_symbols at 0x00, star_flags at 0x08, token_count at 0x10.
// The string arrives on the slave stream one symbol per beat, with tuser low;
// a beat with tuser high ends the string and yields one result beat whose
// bit 0 says whether the whole string matched. Symbol beats give no result.
// An accepted beat is registered in the input register; its position update
// then goes to the state register and a verdict to the output register.
// Throughput: one beat per cycle while no terminator waits on a held verdict;
// the position vector update between input and state registers sets that figure.
// Reset clears the config registers, empties both stream stages and leaves only
// pattern position zero active. When the receiver stalls, the verdict waits
// in the output register and symbol beats keep flowing, since they give no
// result; the next terminator beat then waits in the input register and
// tready drops until the verdict is taken.
`default_nettype none
module wildcard_star_regex_match (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wsr_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [wsr_pkg::CFG_DW-1:0]  pwdata,
	output logic      [wsr_pkg::CFG_DW-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [7:0] symbol
	input  wire logic                        s_axis_tuser,  // [0] terminator
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic      [7:0]                  m_axis_tdata   // [0] matched, [7:1] zero
);

	wsr_pkg::cfg_t             cfg;
	logic                      vld_s1;
	logic [wsr_pkg::SYM_W-1:0] sym_s1;
	logic                      term_s1;
	logic                      adv;
	logic                      match;
	logic                      out_vld_q;
	logic                      matched_q;

	wsr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv           = vld_s1 && (!term_s1 || !out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sym_s1  <= s_axis_tdata;
			term_s1 <= s_axis_tuser;
		end
	end

	wsr_nfa u_nfa (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (adv),
		.symbol     (sym_s1),
		.terminator (term_s1),
		.matched    (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && term_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && term_s1) begin
			matched_q <= match;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, matched_q};

`ifndef SYNTHESIS
	a_verdict_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && term_s1) |=> (m_axis_tvalid && m_axis_tdata[0] == $past(match)))
		else $error("verdict not loaded into the output register");

	a_result_from_terminator: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(adv && term_s1))
		else $error("result beat raised without a terminator step");

	a_stalled_item_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(sym_s1) && $stable(term_s1)))
		else $error("stalled input item was lost or overwritten");
`endif

endmodule
`default_nettype wire

### test/wildcard_star_regex_match_tb.sv
// Self-checking testbench for the streaming wildcard and star pattern matcher.
module wildcard_star_regex_match_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       psel          = 1'b0;
	logic                       penable       = 1'b0;
	logic                       pwrite        = 1'b0;
	logic [wsr_pkg::CFG_AW-1:0] paddr         = '0;
	logic [wsr_pkg::CFG_DW-1:0] pwdata        = '0;
	logic [wsr_pkg::CFG_DW-1:0] prdata;
	logic                       pready;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [7:0]                 s_axis_tdata  = '0;  // [7:0] symbol
	logic                       s_axis_tuser  = 1'b0; // [0] terminator
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [7:0]                 m_axis_tdata;        // [0] matched, [7:1] zero

	logic [wsr_pkg::PAT_W-1:0]      pattern_mirror = '0;
	logic [wsr_pkg::MAX_TOKENS-1:0] star_mirror    = '0;
	logic [wsr_pkg::CNT_W-1:0]      count_mirror   = '0;
	logic [wsr_pkg::POS_W-1:0]      live_positions = wsr_pkg::START_SET;

	logic       verdict_q[$];
	logic [7:0] text_q[$];

	int send_idle_pct = 16;
	int recv_idle_pct = 63;
	int hold_left     = 0;
	int stall_cycles  = 0;
	int error_count   = 0;

	wildcard_star_regex_match uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_error(string msg);
		$display("%0t ERROR %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int used_tokens();
		return (count_mirror > wsr_pkg::TOKENS_MAX) ? wsr_pkg::MAX_TOKENS
			: int'(count_mirror);
	endfunction

	function automatic void apply_cfg(wsr_pkg::reg_idx_t idx, logic [63:0] value);
		case (idx)
			wsr_pkg::REG_PATTERN: pattern_mirror = value[wsr_pkg::PAT_W-1:0];
			wsr_pkg::REG_STAR:    star_mirror = value[wsr_pkg::MAX_TOKENS-1:0];
			wsr_pkg::REG_COUNT:   count_mirror = value[wsr_pkg::CNT_W-1:0];
			default:              ;
		endcase
	endfunction

	// Bits above the token count are dropped, then each starred position also
	// enables the one after it before the set is used.
	function automatic void match_step(logic [7:0] sym, logic term);
		int                        t;
		int                        mask;
		logic [wsr_pkg::POS_W-1:0] cur;
		logic [wsr_pkg::POS_W-1:0] nxt;
		logic [7:0]                tok;
		t = used_tokens();
		mask = (1 << (t + 1)) - 1;
		cur = live_positions & mask[wsr_pkg::POS_W-1:0];
		for (int k = 0; k < t; k++) begin
			if (cur[k] && star_mirror[k])
				cur[k+1] = 1'b1;
		end
		if (term) begin
			verdict_q.push_back(cur[t]);
			live_positions = wsr_pkg::START_SET;
		end else begin
			nxt = '0;
			for (int k = 0; k < t; k++) begin
				tok = pattern_mirror[8*k +: 8];
				if (cur[k] && (tok == wsr_pkg::WILDCARD_SYM || tok == sym)) begin
					if (star_mirror[k])
						nxt[k] = 1'b1;
					else
						nxt[k+1] = 1'b1;
				end
			end
			live_positions = nxt;
		end
	endfunction

	task automatic check_verdict();
		logic want;
		if (verdict_q.size() == 0) begin
			flag_error($sformatf("result beat 0x%02h with no verdict pending", m_axis_tdata));
			return;
		end
		want = verdict_q.pop_front();
		if (m_axis_tdata !== {7'b0, want})
			flag_error($sformatf("matched: expected %0b, got tdata 0x%02h", want, m_axis_tdata));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_verdict();
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(0, 7))
			0:       return "a";
			1:       return "b";
			2:       return wsr_pkg::WILDCARD_SYM;
			3:       return "*";
			4:       return 8'h00;
			5:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly strings spelled out from the current pattern, some of them
	// slightly damaged, the rest loose noise drawn mostly from a small alphabet.
	function automatic void build_text();
		int         t;
		int         reps;
		int         pos;
		logic [7:0] tok;
		text_q.delete();
		t = used_tokens();
		if ($urandom_range(99) < 65) begin
			for (int k = 0; k < t; k++) begin
				tok = pattern_mirror[8*k +: 8];
				reps = star_mirror[k] ? int'($urandom_range(0, 3)) : 1;
				repeat (reps)
					text_q.push_back(tok == wsr_pkg::WILDCARD_SYM
						? 8'($urandom_range(0, 255)) : tok);
			end
			if ($urandom_range(99) < 35) begin
				pos = int'($urandom_range(0, text_q.size()));
				case ($urandom_range(0, 2))
					0: text_q.insert(pos, pick_symbol());
					1: if (pos < text_q.size()) text_q.delete(pos);
					default: if (pos < text_q.size()) text_q[pos] = pick_symbol();
				endcase
			end
		end else begin
			repeat ($urandom_range(0, 8))
				text_q.push_back(pick_symbol());
		end
	endfunction

	task automatic send_item(logic [7:0] sym, logic term);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tuser  <= term;
		do @(posedge clk); while (!s_axis_tready);
		match_step(sym, term);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_item(text_q[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(wsr_pkg::reg_idx_t idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_cfg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pattern(logic [63:0] pat, logic [63:0] star, logic [63:0] cnt);
		drain();
		apb_write(wsr_pkg::REG_PATTERN, pat);
		apb_write(wsr_pkg::REG_STAR, star);
		apb_write(wsr_pkg::REG_COUNT, cnt);
	endtask

	task automatic set_idle(int send_pct, int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(posedge clk);
	endtask

	task automatic random_config();
		logic [63:0] pat;
		logic [63:0] star;
		logic [63:0] cnt;
		case ($urandom_range(0, 9))
			0: pat = '0;
			1: pat = '1;
			default: for (int k = 0; k < wsr_pkg::MAX_TOKENS; k++) pat[8*k +: 8] = pick_symbol();
		endcase
		star = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: star[7:0] = 8'h00;
			1: star[7:0] = 8'hFF;
			default: ;
		endcase
		cnt = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: cnt[3:0] = 4'd0;
			1: cnt[3:0] = 4'd8;
			2: cnt[3:0] = 4'($urandom_range(9, 15));
			default: cnt[3:0] = 4'($urandom_range(1, 8));
		endcase
		set_pattern(pat, star, cnt);
	endtask

	// With no tokens only the empty string matches.
	task automatic test_empty_pattern();
		send_item(8'h00, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
	endtask

	// Zero byte, wildcard, literal star and 0xFF as plain tokens.
	task automatic test_literal_tokens();
		set_pattern({"z", "z", "z", "z", 8'hFF, "*", wsr_pkg::WILDCARD_SYM, 8'h00},
			64'h0, 64'd4);
		text_q = '{8'h00, "x", "*", 8'hFF};
		send_text();
		send_item(8'h01, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	// Wildcard star with zero repeats; flags of tokens past the count are set.
	task automatic test_star_tokens();
		set_pattern({"z", "z", "z", "z", 8'hFF, "*", wsr_pkg::WILDCARD_SYM, 8'h00},
			64'hFFFF_FFFF_FFFF_FFF2, 64'd4);
		text_q = '{8'h00, "*", 8'hFF};
		send_text();
	endtask

	// A count above the maximum uses all tokens; an unmapped register is ignored.
	task automatic test_config_edges();
		drain();
		apb_write(wsr_pkg::REG_COUNT, 64'h0F);
		text_q = '{8'h00, "*", 8'hFF, "z"};
		send_text();
		send_item(8'h00, 1'b1);
		drain();
		apb_write(wsr_pkg::REG_NONE, 64'h0);
		text_q = '{8'h00, "*", 8'hFF};
		send_text();
	endtask

	// The count shrinks between the last symbol and the terminator.
	task automatic test_midstring_config();
		set_pattern(64'h6261, 64'h0, 64'd2);
		send_item("a", 1'b0);
		drain();
		apb_write(wsr_pkg::REG_COUNT, 64'd1);
		send_item(8'h00, 1'b1);
	endtask

	task automatic test_random_strings(int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			random_config();
			repeat (6) begin
				build_text();
				sent += text_q.size() + 1;
				send_text();
			end
		end
		drain();
	endtask

	// Short strings keep verdicts coming while the receiver is held off.
	task automatic test_backpressure();
		random_config();
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		@(posedge clk);
		repeat (12) begin
			text_q.delete();
			repeat ($urandom_range(0, 2))
				text_q.push_back(pick_symbol());
			send_text();
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pattern();
		test_literal_tokens();
		test_star_tokens();
		test_config_edges();
		test_midstring_config();
		test_random_strings(180);
		set_idle(63, 16);
		test_random_strings(190);
		set_idle(0, 0);
		test_random_strings(190);
		test_backpressure();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
